@@ rtl/lrk_pkg.sv @@
// Shared types, constants and the RK4 step microprogram for the Lorenz integrator.
// Used by lrk_controller, lrk_datapath and lorenz_rk4_integrator_core.
`timescale 1ns / 1ps

package lrk_pkg;

	// Default arithmetic and sequencing sizes
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 20;
	localparam int MAX_STEPS_DEF = 63;

	// Port field widths fixed by the interface
	localparam int IO_BITS    = 32;
	localparam int CNT_BITS   = 6;
	localparam int GAIN_BITS  = 31;
	localparam int DT_BITS    = 21;
	localparam int CFG_BITS   = 31;
	localparam int CIDX_BITS  = 2;
	localparam int TDATA_BITS = 104;

	// Configuration register indexes and reset values
	localparam logic [CIDX_BITS-1:0] REG_SIGMA = 2'd0;
	localparam logic [CIDX_BITS-1:0] REG_RHO   = 2'd1;
	localparam logic [CIDX_BITS-1:0] REG_BETA  = 2'd2;
	localparam logic [CIDX_BITS-1:0] REG_DT    = 2'd3;
	localparam logic [GAIN_BITS-1:0] SIGMA_RST = 31'd10485760;
	localparam logic [GAIN_BITS-1:0] RHO_RST   = 31'd29360128;
	localparam logic [GAIN_BITS-1:0] BETA_RST  = 31'd2796203;
	localparam logic [DT_BITS-1:0]   DT_RST    = 21'd10486;

	// Operand / destination addresses: scratch memory below MEM_DEPTH, named registers at MEM_DEPTH and above
	typedef logic [4:0] addr_t;
	localparam int MEM_DEPTH = 17;
	localparam addr_t A_P0 = 5'd0;
	localparam addr_t A_P1 = 5'd1;
	localparam addr_t A_P2 = 5'd2;
	localparam addr_t A_K1X = 5'd3;
	localparam addr_t A_K1Y = 5'd4;
	localparam addr_t A_K1Z = 5'd5;
	localparam addr_t A_K2X = 5'd6;
	localparam addr_t A_K2Y = 5'd7;
	localparam addr_t A_K2Z = 5'd8;
	localparam addr_t A_K3X = 5'd9;
	localparam addr_t A_K3Y = 5'd10;
	localparam addr_t A_K3Z = 5'd11;
	localparam addr_t A_K4X = 5'd12;
	localparam addr_t A_K4Y = 5'd13;
	localparam addr_t A_K4Z = 5'd14;
	localparam addr_t A_T0 = 5'd15;
	localparam addr_t A_T1 = 5'd16;
	localparam addr_t A_X  = 5'd17;
	localparam addr_t A_Y  = 5'd18;
	localparam addr_t A_Z  = 5'd19;
	localparam addr_t A_SG = 5'd20;
	localparam addr_t A_RH = 5'd21;
	localparam addr_t A_BT = 5'd22;
	localparam addr_t A_DT = 5'd23;
	localparam addr_t A_HF = 5'd24;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_SUB  = 2'd1,
		OP_MUL  = 2'd2,
		OP_DIV6 = 2'd3
	} op_t;

	typedef struct packed {
		op_t   op;
		addr_t dst;
		addr_t src_a;
		addr_t src_b;
	} instr_t;

	localparam int PC_BITS  = 7;
	localparam int PROG_LEN = 74;

	// Controller to datapath commands
	typedef struct packed {
		logic                load_start;
		logic                emit;
		logic                ph_read;
		logic                ph_exec;
		logic                ph_write;
		instr_t              instr;
		logic [CNT_BITS-1:0] point_index;
		logic                last_point;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} status_t;

	function automatic instr_t mk(op_t op, addr_t d, addr_t a, addr_t b);
		instr_t r;
		r.op    = op;
		r.dst   = d;
		r.src_a = a;
		r.src_b = b;
		return r;
	endfunction

	// One RK4 step: four slopes, three probe points, weighted update of x, y, z
	function automatic instr_t prog_at(logic [PC_BITS-1:0] pc);
		instr_t r;
		r = mk(OP_ADD, A_T0, A_T0, A_T0);
		case (pc)
			7'd0:  r = mk(OP_SUB, A_T0,  A_Y,   A_X);
			7'd1:  r = mk(OP_MUL, A_K1X, A_SG,  A_T0);
			7'd2:  r = mk(OP_SUB, A_T0,  A_RH,  A_Z);
			7'd3:  r = mk(OP_MUL, A_T0,  A_X,   A_T0);
			7'd4:  r = mk(OP_SUB, A_K1Y, A_T0,  A_Y);
			7'd5:  r = mk(OP_MUL, A_T0,  A_X,   A_Y);
			7'd6:  r = mk(OP_MUL, A_T1,  A_BT,  A_Z);
			7'd7:  r = mk(OP_SUB, A_K1Z, A_T0,  A_T1);
			7'd8:  r = mk(OP_MUL, A_P0,  A_K1X, A_HF);
			7'd9:  r = mk(OP_ADD, A_P0,  A_X,   A_P0);
			7'd10: r = mk(OP_MUL, A_P1,  A_K1Y, A_HF);
			7'd11: r = mk(OP_ADD, A_P1,  A_Y,   A_P1);
			7'd12: r = mk(OP_MUL, A_P2,  A_K1Z, A_HF);
			7'd13: r = mk(OP_ADD, A_P2,  A_Z,   A_P2);
			7'd14: r = mk(OP_SUB, A_T0,  A_P1,  A_P0);
			7'd15: r = mk(OP_MUL, A_K2X, A_SG,  A_T0);
			7'd16: r = mk(OP_SUB, A_T0,  A_RH,  A_P2);
			7'd17: r = mk(OP_MUL, A_T0,  A_P0,  A_T0);
			7'd18: r = mk(OP_SUB, A_K2Y, A_T0,  A_P1);
			7'd19: r = mk(OP_MUL, A_T0,  A_P0,  A_P1);
			7'd20: r = mk(OP_MUL, A_T1,  A_BT,  A_P2);
			7'd21: r = mk(OP_SUB, A_K2Z, A_T0,  A_T1);
			7'd22: r = mk(OP_MUL, A_P0,  A_K2X, A_HF);
			7'd23: r = mk(OP_ADD, A_P0,  A_X,   A_P0);
			7'd24: r = mk(OP_MUL, A_P1,  A_K2Y, A_HF);
			7'd25: r = mk(OP_ADD, A_P1,  A_Y,   A_P1);
			7'd26: r = mk(OP_MUL, A_P2,  A_K2Z, A_HF);
			7'd27: r = mk(OP_ADD, A_P2,  A_Z,   A_P2);
			7'd28: r = mk(OP_SUB, A_T0,  A_P1,  A_P0);
			7'd29: r = mk(OP_MUL, A_K3X, A_SG,  A_T0);
			7'd30: r = mk(OP_SUB, A_T0,  A_RH,  A_P2);
			7'd31: r = mk(OP_MUL, A_T0,  A_P0,  A_T0);
			7'd32: r = mk(OP_SUB, A_K3Y, A_T0,  A_P1);
			7'd33: r = mk(OP_MUL, A_T0,  A_P0,  A_P1);
			7'd34: r = mk(OP_MUL, A_T1,  A_BT,  A_P2);
			7'd35: r = mk(OP_SUB, A_K3Z, A_T0,  A_T1);
			7'd36: r = mk(OP_MUL, A_P0,  A_K3X, A_DT);
			7'd37: r = mk(OP_ADD, A_P0,  A_X,   A_P0);
			7'd38: r = mk(OP_MUL, A_P1,  A_K3Y, A_DT);
			7'd39: r = mk(OP_ADD, A_P1,  A_Y,   A_P1);
			7'd40: r = mk(OP_MUL, A_P2,  A_K3Z, A_DT);
			7'd41: r = mk(OP_ADD, A_P2,  A_Z,   A_P2);
			7'd42: r = mk(OP_SUB, A_T0,  A_P1,  A_P0);
			7'd43: r = mk(OP_MUL, A_K4X, A_SG,  A_T0);
			7'd44: r = mk(OP_SUB, A_T0,  A_RH,  A_P2);
			7'd45: r = mk(OP_MUL, A_T0,  A_P0,  A_T0);
			7'd46: r = mk(OP_SUB, A_K4Y, A_T0,  A_P1);
			7'd47: r = mk(OP_MUL, A_T0,  A_P0,  A_P1);
			7'd48: r = mk(OP_MUL, A_T1,  A_BT,  A_P2);
			7'd49: r = mk(OP_SUB, A_K4Z, A_T0,  A_T1);
			7'd50: r = mk(OP_ADD, A_T0,  A_K2X, A_K2X);
			7'd51: r = mk(OP_ADD, A_T0,  A_K1X, A_T0);
			7'd52: r = mk(OP_ADD, A_T1,  A_K3X, A_K3X);
			7'd53: r = mk(OP_ADD, A_T0,  A_T0,  A_T1);
			7'd54: r = mk(OP_ADD, A_T0,  A_T0,  A_K4X);
			7'd55: r = mk(OP_MUL, A_T0,  A_T0,  A_DT);
			7'd56: r = mk(OP_DIV6, A_T0, A_T0,  A_T0);
			7'd57: r = mk(OP_ADD, A_X,   A_X,   A_T0);
			7'd58: r = mk(OP_ADD, A_T0,  A_K2Y, A_K2Y);
			7'd59: r = mk(OP_ADD, A_T0,  A_K1Y, A_T0);
			7'd60: r = mk(OP_ADD, A_T1,  A_K3Y, A_K3Y);
			7'd61: r = mk(OP_ADD, A_T0,  A_T0,  A_T1);
			7'd62: r = mk(OP_ADD, A_T0,  A_T0,  A_K4Y);
			7'd63: r = mk(OP_MUL, A_T0,  A_T0,  A_DT);
			7'd64: r = mk(OP_DIV6, A_T0, A_T0,  A_T0);
			7'd65: r = mk(OP_ADD, A_Y,   A_Y,   A_T0);
			7'd66: r = mk(OP_ADD, A_T0,  A_K2Z, A_K2Z);
			7'd67: r = mk(OP_ADD, A_T0,  A_K1Z, A_T0);
			7'd68: r = mk(OP_ADD, A_T1,  A_K3Z, A_K3Z);
			7'd69: r = mk(OP_ADD, A_T0,  A_T0,  A_T1);
			7'd70: r = mk(OP_ADD, A_T0,  A_T0,  A_K4Z);
			7'd71: r = mk(OP_MUL, A_T0,  A_T0,  A_DT);
			7'd72: r = mk(OP_DIV6, A_T0, A_T0,  A_T0);
			7'd73: r = mk(OP_ADD, A_Z,   A_Z,   A_T0);
			default: r = mk(OP_ADD, A_T0, A_T0, A_T0);
		endcase
		return r;
	endfunction

endpackage

@@ rtl/lorenz_rk4_integrator_core.sv @@
// Lorenz attractor RK4 integrator top level: ports, controller and datapath.
// Depends on lrk_pkg, lrk_controller and lrk_datapath.
`timescale 1ns / 1ps
//
// Usage:
//  - Input stream (s_tvalid/s_tready/s_tdata) carries one start point and a step
//    count n per transaction. The block emits the start point, then the point after
//    each of n RK4 steps (n clamped to MAX_STEPS) on the output stream; m_tlast marks
//    the final point of the item.
//  - Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes sigma,
//    rho, beta and dt; always ready, write only while idle.
//  - One RK4 step runs 74 microinstructions, each as a read, an execute and a write-back
//    phase, on one shared saturating ALU and multiplier.
//  - s_tready is high only while no item is in progress; the output register lets
//    the next item be taken while the last point still waits.
//  - When the receiver stalls, the sequencer holds before each emit until the output
//    register frees; nothing is dropped.
//  - Reset clears control state and restores the configuration defaults.
//
module lorenz_rk4_integrator_core #(
	parameter int WORD_BITS = lrk_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = lrk_pkg::FRAC_BITS_DEF,
	parameter int MAX_STEPS = lrk_pkg::MAX_STEPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// start_x[31:0], start_y[63:32], start_z[95:64], step_count[101:96], zero fill
	input  logic [lrk_pkg::TDATA_BITS-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// point_x[31:0], point_y[63:32], point_z[95:64], point_index[101:96], zero fill
	output logic [lrk_pkg::TDATA_BITS-1:0]  m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lrk_pkg::CIDX_BITS-1:0]   cfg_index,
	input  logic [lrk_pkg::CFG_BITS-1:0]    cfg_data
);
	import lrk_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	lrk_controller #(
		.MAX_STEPS (MAX_STEPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.step_count (s_tdata[101:96]),
		.status     (status),
		.cmd        (cmd)
	);

	lrk_datapath #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start_x   (s_tdata[31:0]),
		.start_y   (s_tdata[63:32]),
		.start_z   (s_tdata[95:64]),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Block turns busy after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	// Emit only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("output overwritten before taken");

	// Write back always follows execute
	a_phase_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ph_write |-> $past(cmd.ph_exec))
		else $error("write back without execute");

endmodule

@@ rtl/lrk_controller.sv @@
// Sequencer for the Lorenz integrator: takes items, emits points, steps the RK4 microprogram.
// Depends on lrk_pkg for the command/status structs and the microprogram table.
`timescale 1ns / 1ps

module lrk_controller #(
	parameter int MAX_STEPS = lrk_pkg::MAX_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lrk_pkg::CNT_BITS-1:0]  step_count,
	input  lrk_pkg::status_t              status,
	output lrk_pkg::cmd_t                 cmd
);
	import lrk_pkg::*;

	localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_STEPS);
	localparam logic [PC_BITS-1:0]  LAST_PC = PC_BITS'(PROG_LEN - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EMIT = 3'b010,
		ST_RUN  = 3'b100
	} state_t;

	state_t               state_q;
	logic [CNT_BITS-1:0]  left_q;
	logic [CNT_BITS-1:0]  idx_q;
	logic [PC_BITS-1:0]   pc_q;
	logic [1:0]           ph_q;
	logic                 accept;
	logic                 emit;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign emit     = (state_q == ST_EMIT) && status.out_free;

	// Drive datapath commands
	always_comb begin
		cmd             = '0;
		cmd.load_start  = accept;
		cmd.emit        = emit;
		cmd.ph_read     = (state_q == ST_RUN) && (ph_q == 2'd0);
		cmd.ph_exec     = (state_q == ST_RUN) && (ph_q == 2'd1);
		cmd.ph_write    = (state_q == ST_RUN) && (ph_q == 2'd2);
		cmd.instr       = prog_at(pc_q);
		cmd.point_index = idx_q;
		cmd.last_point  = (left_q == '0);
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
			idx_q   <= '0;
			pc_q    <= '0;
			ph_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						left_q  <= (step_count > MAX_CNT) ? MAX_CNT : step_count;
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						pc_q    <= '0;
						ph_q    <= '0;
						state_q <= (left_q == '0) ? ST_IDLE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						if (pc_q == LAST_PC) begin
							left_q  <= left_q - 1'b1;
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_EMIT;
						end else begin
							pc_q <= pc_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/lrk_datapath.sv @@
// Datapath of the Lorenz integrator: config registers, point and scratch storage,
// one shared saturating ALU / multiplier, output register. Depends on lrk_pkg.
`timescale 1ns / 1ps

module lrk_datapath #(
	parameter int WORD_BITS = lrk_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = lrk_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lrk_pkg::CIDX_BITS-1:0]   cfg_index,
	input  logic [lrk_pkg::CFG_BITS-1:0]    cfg_data,
	input  logic [lrk_pkg::IO_BITS-1:0]     start_x,
	input  logic [lrk_pkg::IO_BITS-1:0]     start_y,
	input  logic [lrk_pkg::IO_BITS-1:0]     start_z,
	input  lrk_pkg::cmd_t                   cmd,
	output lrk_pkg::status_t                status,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lrk_pkg::TDATA_BITS-1:0]  m_tdata,
	output logic                            m_tlast
);
	import lrk_pkg::*;

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam logic [63:0]  SMAX64 = (64'd1 << (W - 1)) - 64'd1;
	localparam logic [W-1:0] SMAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN   = {1'b1, {(W-1){1'b0}}};
	localparam logic [W+2:0] RECIP_FULL = ({{(W+2){1'b0}}, 1'b1} << (W + 2)) / 6;
	localparam logic [W-1:0] RECIP  = RECIP_FULL[W-1:0];
	localparam logic [2*W:0] RND    = {{(2*W){1'b0}}, 1'b1} << (F - 1);

	logic [GAIN_BITS-1:0] sigma_q, rho_q, beta_q;
	logic [DT_BITS-1:0]   dt_q;
	logic [W-1:0]         x_q, y_q, z_q;
	logic [W-1:0]         mem [MEM_DEPTH];
	logic [W-1:0]         ra_q, rb_q, na_q, nb_q;
	logic                 sel_a_q, sel_b_q;
	logic [W-1:0]         sg, rh, bt, dt, hf;
	logic [W-1:0]         opa, opb;
	logic [W-1:0]         res_q;
	logic [2*W-1:0]       prod_q;
	logic [W-1:0]         m_q;
	logic                 neg_q;
	logic [W-1:0]         wval;
	logic                 out_v_q;
	logic [TDATA_BITS-1:0] out_d_q;
	logic                 out_l_q;

	// Clamp an unsigned register value to the signed word
	function automatic logic [W-1:0] reg_clamp(logic [GAIN_BITS-1:0] r);
		logic [63:0] v;
		v = {{(64-GAIN_BITS){1'b0}}, r};
		return (v > SMAX64) ? SMAX : v[W-1:0];
	endfunction

	// Fit a 32-bit signed input to the word
	function automatic logic [W-1:0] in_clamp(logic [IO_BITS-1:0] s);
		logic signed [63:0] v;
		v = 64'(signed'(s));
		if (v > signed'(SMAX64)) return SMAX;
		if (v < -signed'(SMAX64) - 64'sd1) return SMIN;
		return v[W-1:0];
	endfunction

	// Fit the word to a 32-bit signed output
	function automatic logic [IO_BITS-1:0] out_clamp(logic [W-1:0] s);
		logic signed [64:0] v;
		v = 65'(signed'(s));
		if (v > 65'sd2147483647) return 32'h7fffffff;
		if (v < -65'sd2147483648) return 32'h80000000;
		return v[IO_BITS-1:0];
	endfunction

	function automatic logic [W-1:0] mag(logic [W-1:0] a);
		return a[W-1] ? (~a + 1'b1) : a;
	endfunction

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RST;
			rho_q   <= RHO_RST;
			beta_q  <= BETA_RST;
			dt_q    <= DT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIGMA: sigma_q <= cfg_data;
				REG_RHO:   rho_q   <= cfg_data;
				REG_BETA:  beta_q  <= cfg_data;
				REG_DT:    dt_q    <= cfg_data[DT_BITS-1:0];
				default:   sigma_q <= sigma_q;
			endcase
		end
	end

	assign sg = reg_clamp(sigma_q);
	assign rh = reg_clamp(rho_q);
	assign bt = reg_clamp(beta_q);
	assign dt = reg_clamp({{(GAIN_BITS-DT_BITS){1'b0}}, dt_q});
	assign hf = W'(({1'b0, dt} + 1'b1) >> 1);

	function automatic logic [W-1:0] named(addr_t a);
		logic [W-1:0] r;
		case (a)
			A_X:     r = x_q;
			A_Y:     r = y_q;
			A_Z:     r = z_q;
			A_SG:    r = sg;
			A_RH:    r = rh;
			A_BT:    r = bt;
			A_DT:    r = dt;
			A_HF:    r = hf;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Read operands from scratch memory and named registers
	always_ff @(posedge clk) begin
		if (cmd.ph_read) begin
			ra_q    <= mem[cmd.instr.src_a];
			rb_q    <= mem[cmd.instr.src_b];
			na_q    <= named(cmd.instr.src_a);
			nb_q    <= named(cmd.instr.src_b);
			sel_a_q <= (cmd.instr.src_a >= addr_t'(MEM_DEPTH));
			sel_b_q <= (cmd.instr.src_b >= addr_t'(MEM_DEPTH));
		end
	end

	assign opa = sel_a_q ? na_q : ra_q;
	assign opb = sel_b_q ? nb_q : rb_q;

	// Execute: saturating add/sub, or one shared multiply for multiply and divide by six
	always_ff @(posedge clk) begin
		logic [W:0]   s;
		logic [W-1:0] mx, my;
		if (cmd.ph_exec) begin
			s  = '0;
			mx = mag(opa);
			my = mag(opb);
			case (cmd.instr.op)
				OP_ADD: s = {opa[W-1], opa} + {opb[W-1], opb};
				OP_SUB: s = {opa[W-1], opa} - {opb[W-1], opb};
				OP_DIV6: begin
					mx = mag(opa) + W'(3);
					my = RECIP;
				end
				default: s = '0;
			endcase
			res_q  <= (s[W] != s[W-1]) ? (s[W] ? SMIN : SMAX) : s[W-1:0];
			prod_q <= mx * my;
			m_q    <= mx;
			neg_q  <= (cmd.instr.op == OP_DIV6) ? opa[W-1] : (opa[W-1] ^ opb[W-1]);
		end
	end

	// Round and saturate the product, finish the divide by six, or pass the add/sub result
	always_comb begin
		logic [2*W:0] q;
		logic [W-1:0] q0, r, qd;
		q  = ({1'b0, prod_q} + RND) >> F;
		q0 = W'(prod_q >> (W + 2));
		r  = m_q - ((q0 << 2) + (q0 << 1));
		qd = q0 + W'(r >= W'(6));
		wval = res_q;
		case (cmd.instr.op)
			OP_MUL: begin
				if (!neg_q) wval = (q > (2*W+1)'(SMAX)) ? SMAX : q[W-1:0];
				else wval = (q >= (2*W+1)'(SMIN)) ? SMIN : (~q[W-1:0] + 1'b1);
			end
			OP_DIV6: wval = neg_q ? (~qd + 1'b1) : qd;
			default: wval = res_q;
		endcase
	end

	// Write back the result, load the start point
	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			x_q <= in_clamp(start_x);
			y_q <= in_clamp(start_y);
			z_q <= in_clamp(start_z);
		end else if (cmd.ph_write) begin
			if (cmd.instr.dst == A_X) x_q <= wval;
			if (cmd.instr.dst == A_Y) y_q <= wval;
			if (cmd.instr.dst == A_Z) z_q <= wval;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ph_write && (cmd.instr.dst < addr_t'(MEM_DEPTH)))
			mem[cmd.instr.dst] <= wval;
	end

	// Hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.emit) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_d_q <= {2'b00, cmd.point_index, out_clamp(z_q), out_clamp(y_q), out_clamp(x_q)};
			out_l_q <= cmd.last_point;
		end
	end

	assign status.out_free = !out_v_q || m_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tlast  = out_l_q;

endmodule
